// ===== design/stick_to_velocity_reference_defines.svh =====
// ----------------------------------------------------------------------------
// Stick-to-velocity reference: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STICK_TO_VELOCITY_REFERENCE_DEFINES_SVH
`define STICK_TO_VELOCITY_REFERENCE_DEFINES_SVH

// same-cycle implication
`define STV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/stv_pkg.sv =====
// ----------------------------------------------------------------------------
// stv_pkg
// Types and constants shared by the stick-to-velocity reference block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stv_pkg;

  localparam int ATAN_N     = 24;
  localparam int ATAN_IDX_W = 5;

  // atan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] ATAN_TABLE [ATAN_N] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // CORDIC start x: gain-compensated unit, Q2.30
  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  localparam int ACC_W = 50;

  localparam logic [1:0] REG_HSPEED = 2'd0;
  localparam logic [1:0] REG_VSPEED = 2'd1;
  localparam logic [1:0] REG_TURN   = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  localparam logic ACT_COMPUTE = 1'b0;
  localparam logic ACT_FORGET  = 1'b1;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } cs_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ITER,
    C_OUT
  } cordic_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROT,
    ST_VX0,
    ST_VX1,
    ST_VX2,
    ST_VX3,
    ST_VY0,
    ST_VY1,
    ST_VY2,
    ST_VY3,
    ST_VZ,
    ST_YAW0,
    ST_RATE,
    ST_HD0,
    ST_HD1,
    ST_HD2,
    ST_QUAT,
    ST_DONE
  } stv_state_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_CLR,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

endpackage

// ===== design/stv_cordic.sv =====
// ----------------------------------------------------------------------------
// stv_cordic
// Iterative CORDIC rotator: cosine and sine of a 32-bit binary angle, Q1.15,
// one micro-rotation per cycle with a shared shifter and adder set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stick_to_velocity_reference_defines.svh"

module stv_cordic #(
  parameter int STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [31:0]  angle,
  output logic         done,
  output stv_pkg::cs_t res
);
  import stv_pkg::*;

  localparam int NSTEP = (STEPS < ATAN_N) ? STEPS : ATAN_N;
  localparam int XW    = 34;
  localparam logic signed [XW-1:0] X0   = XW'(signed'({1'b0, CORDIC_X0}));
  localparam logic signed [XW-1:0] HALF = XW'(64'sd1073741824);
  localparam logic signed [XW-1:0] FULL = XW'(64'sd2147483648);
  localparam logic signed [XW-1:0] RND  = XW'(64'sd16384);
  localparam logic signed [XW-1:0] SMAX = XW'(64'sd32767);
  localparam logic signed [XW-1:0] SMIN = -XW'(64'sd32768);

  cordic_state_t          state_r, state_nxt;
  logic [ATAN_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic signed [XW-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                   neg_r, neg_nxt;
  logic                   done_r, done_nxt;
  cs_t                    res_r, res_nxt;

  logic signed [XW-1:0]   xs, ys, at, z0, xf, yf, xrnd, yrnd;

  function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
    logic signed [15:0] r;
    if (v > SMAX) begin
      r = 16'sh7FFF;
    end else if (v < SMIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    xs        = x_r >>> cnt_r;
    ys        = y_r >>> cnt_r;
    at        = XW'(signed'({1'b0, ATAN_TABLE[cnt_r]}));
    z0        = XW'(signed'(angle));
    xf        = neg_r ? -x_r : x_r;
    yf        = neg_r ? -y_r : y_r;
    xrnd      = (xf + RND) >>> 15;
    yrnd      = (yf + RND) >>> 15;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          x_nxt   = X0;
          y_nxt   = '0;
          cnt_nxt = '0;
          // fold into the right half plane
          if (z0 > HALF) begin
            z_nxt   = z0 - FULL;
            neg_nxt = 1'b1;
          end else if (z0 < -HALF) begin
            z_nxt   = z0 + FULL;
            neg_nxt = 1'b1;
          end else begin
            z_nxt   = z0;
            neg_nxt = 1'b0;
          end
          state_nxt = C_ITER;
        end
      end
      C_ITER: begin
        if (!z_r[XW-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
        if (cnt_r == ATAN_IDX_W'(NSTEP - 1)) begin
          state_nxt = C_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      C_OUT: begin
        res_nxt.cos_v = sat16(xrnd);
        res_nxt.sin_v = sat16(yrnd);
        done_nxt      = 1'b1;
        state_nxt     = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

  `STV_ASSERT_IMP(a_start_idle, start, state_r == C_IDLE, "cordic started while busy")
  `STV_ASSERT_IMP(a_done_idle, done_r, state_r == C_IDLE, "cordic done outside idle")
  `STV_ASSERT_IMP(a_cnt_range, state_r == C_ITER, cnt_r < ATAN_IDX_W'(NSTEP), "step count overrun")

endmodule

// ===== design/stick_to_velocity_reference.sv =====
// ----------------------------------------------------------------------------
// stick_to_velocity_reference
// Sequence: rate mode runs one CORDIC rotation, then the MAC steps to out_valid;
// attitude mode adds heading integration (two CORDIC runs, one step a cycle).
// Throughput: one item at a time; in_stall is high from accept until the
// result is handed to the output register. A forget item is taken without leaving idle.
// Reset (synchronous, rst_n low): registers to defaults, heading reference
// unseeded, output empty.
// Rotates the right stick by heading, scales sticks by the speed limits and
// keeps an integrated heading reference in attitude mode, using one shared 17x17 MAC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stick_to_velocity_reference_defines.svh"

module stick_to_velocity_reference #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_left_x,
  input  logic signed [15:0] in_left_y,
  input  logic signed [15:0] in_right_x,
  input  logic signed [15:0] in_right_y,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic signed [15:0] out_vel_z,
  output logic signed [16:0] out_yaw_rate,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic               out_orient_mode,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import stv_pkg::*;

  localparam logic signed [ACC_W-1:0] RND30 = ACC_W'(64'sd536870912);
  localparam logic signed [ACC_W-1:0] RND15 = ACC_W'(64'sd16384);
  localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(64'sd32767);
  localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(64'sd32768);
  localparam logic signed [ACC_W-1:0] S17_MAX = ACC_W'(64'sd65535);
  localparam logic signed [ACC_W-1:0] S17_MIN = -ACC_W'(64'sd65535);

  stv_state_t state_r, state_nxt;

  logic [15:0] hspd_r, vspd_r, turn_r;
  logic        rmode_r;
  logic [31:0] tgt_r;
  logic        tgt_vld_r;

  logic signed [15:0] lx_r, ly_r, rx_r, ry_r;
  logic [15:0]        dt_r;
  logic signed [15:0] c_r, s_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [32:0]        sum_r;

  logic signed [15:0] vx_w_r, vy_w_r, vz_w_r, qz_w_r, qw_w_r;
  logic signed [16:0] rate_w_r;

  logic               out_valid_r;
  logic signed [15:0] out_vx_r, out_vy_r, out_vz_r, out_qz_r, out_qw_r;
  logic signed [16:0] out_yaw_r;
  logic               out_mode_r;

  logic        accept, cfg_wr;
  logic        cs_start, cs_done;
  logic [31:0] cs_angle;
  cs_t         cs_res;

  mac_op_t            mac_op;
  logic signed [16:0] mac_a, mac_b;
  logic               mac_sh;
  logic               sum_ld, out_ld;
  logic signed [33:0] prod;
  logic signed [ACC_W-1:0] prod_ext, prod_sh, r30, r15;
  logic [31:0]        tgt_sum;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = 16'sh7FFF;
    end else if (v < S16_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [ACC_W-1:0] v);
    logic signed [16:0] r;
    if (v > S17_MAX) begin
      r = 17'sh0FFFF;
    end else if (v < S17_MIN) begin
      r = 17'sh10001;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  stv_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .angle (cs_angle),
    .done  (cs_done),
    .res   (cs_res)
  );

  // shared MAC
  assign prod     = mac_a * mac_b;
  assign prod_ext = ACC_W'(prod);
  assign prod_sh  = mac_sh ? (prod_ext <<< 16) : prod_ext;
  assign r30      = (acc_r + RND30) >>> 30;
  assign r15      = (acc_r + RND15) >>> 15;
  assign tgt_sum  = tgt_r + r15[31:0];

  always_comb begin
    case (mac_op)
      MAC_CLR: acc_nxt = prod_sh;
      MAC_ADD: acc_nxt = acc_r + prod_sh;
      MAC_SUB: acc_nxt = acc_r - prod_sh;
      default: acc_nxt = acc_r;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cs_start  = 1'b0;
    cs_angle  = {in_heading, 16'h0000};
    mac_op    = MAC_HOLD;
    mac_a     = '0;
    mac_b     = '0;
    mac_sh    = 1'b0;
    sum_ld    = 1'b0;
    out_ld    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_action == ACT_COMPUTE) begin
          cs_start  = 1'b1;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (cs_done) begin
          state_nxt = ST_VX0;
        end
      end
      ST_VX0: begin
        mac_op = MAC_CLR; mac_a = {c_r[15], c_r}; mac_b = {ry_r[15], ry_r};
        state_nxt = ST_VX1;
      end
      ST_VX1: begin
        mac_op = MAC_ADD; mac_a = {s_r[15], s_r}; mac_b = {rx_r[15], rx_r};
        state_nxt = ST_VX2;
      end
      ST_VX2: begin
        mac_op = MAC_CLR; mac_a = {1'b0, hspd_r}; mac_b = {1'b0, acc_r[15:0]};
        sum_ld = 1'b1;
        state_nxt = ST_VX3;
      end
      ST_VX3: begin
        mac_op = MAC_ADD; mac_a = {1'b0, hspd_r}; mac_b = sum_r[32:16]; mac_sh = 1'b1;
        state_nxt = ST_VY0;
      end
      ST_VY0: begin
        mac_op = MAC_CLR; mac_a = {s_r[15], s_r}; mac_b = {ry_r[15], ry_r};
        state_nxt = ST_VY1;
      end
      ST_VY1: begin
        mac_op = MAC_SUB; mac_a = {c_r[15], c_r}; mac_b = {rx_r[15], rx_r};
        state_nxt = ST_VY2;
      end
      ST_VY2: begin
        mac_op = MAC_CLR; mac_a = {1'b0, hspd_r}; mac_b = {1'b0, acc_r[15:0]};
        sum_ld = 1'b1;
        state_nxt = ST_VY3;
      end
      ST_VY3: begin
        mac_op = MAC_ADD; mac_a = {1'b0, hspd_r}; mac_b = sum_r[32:16]; mac_sh = 1'b1;
        state_nxt = ST_VZ;
      end
      ST_VZ: begin
        mac_op = MAC_CLR; mac_a = {1'b0, vspd_r}; mac_b = {ly_r[15], ly_r};
        state_nxt = ST_YAW0;
      end
      ST_YAW0: begin
        mac_op = MAC_CLR; mac_a = {1'b0, turn_r}; mac_b = -{lx_r[15], lx_r};
        state_nxt = rmode_r ? ST_RATE : ST_HD0;
      end
      ST_RATE: begin
        state_nxt = ST_DONE;
      end
      ST_HD0: begin
        mac_op = MAC_CLR; mac_a = {1'b0, dt_r}; mac_b = {1'b0, acc_r[15:0]};
        sum_ld = 1'b1;
        state_nxt = ST_HD1;
      end
      ST_HD1: begin
        mac_op = MAC_ADD; mac_a = {1'b0, dt_r}; mac_b = sum_r[32:16]; mac_sh = 1'b1;
        state_nxt = ST_HD2;
      end
      ST_HD2: begin
        cs_start  = 1'b1;
        cs_angle  = {1'b0, tgt_sum[31:1]};
        state_nxt = ST_QUAT;
      end
      ST_QUAT: begin
        if (cs_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_ld    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hspd_r      <= 16'd256;
      vspd_r      <= 16'd256;
      turn_r      <= 16'd8192;
      rmode_r     <= 1'b0;
      tgt_r       <= '0;
      tgt_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_HSPEED: hspd_r  <= pwdata[15:0];
          REG_VSPEED: vspd_r  <= pwdata[15:0];
          REG_TURN:   turn_r  <= pwdata[15:0];
          REG_MODE:   rmode_r <= pwdata[0];
          default:    ;
        endcase
      end
      if (accept) begin
        if (in_action == ACT_FORGET) begin
          tgt_vld_r <= 1'b0;
        end else if (!tgt_vld_r) begin
          tgt_r     <= {in_heading, 16'h0000};
          tgt_vld_r <= 1'b1;
        end
      end
      if (state_r == ST_HD2) begin
        tgt_r <= tgt_sum;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lx_r <= in_left_x;
      ly_r <= in_left_y;
      rx_r <= in_right_x;
      ry_r <= in_right_y;
      dt_r <= in_time_step;
    end
    if (state_r == ST_ROT && cs_done) begin
      c_r <= cs_res.cos_v;
      s_r <= cs_res.sin_v;
    end
    if (state_r == ST_QUAT && cs_done) begin
      qw_w_r <= cs_res.cos_v;
      qz_w_r <= cs_res.sin_v;
    end
    acc_r <= acc_nxt;
    if (sum_ld) begin
      sum_r <= acc_r[32:0];
    end
    if (state_r == ST_VY0) begin
      vx_w_r <= sat16(r30);
    end
    if (state_r == ST_VZ) begin
      vy_w_r <= sat16(r30);
    end
    if (state_r == ST_YAW0) begin
      vz_w_r <= sat16(r15);
    end
    if (state_r == ST_RATE) begin
      rate_w_r <= sat17(r15);
    end
    if (out_ld) begin
      out_vx_r   <= vx_w_r;
      out_vy_r   <= vy_w_r;
      out_vz_r   <= vz_w_r;
      out_yaw_r  <= rmode_r ? rate_w_r : '0;
      out_qz_r   <= rmode_r ? '0 : qz_w_r;
      out_qw_r   <= rmode_r ? '0 : qw_w_r;
      out_mode_r <= ~rmode_r;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HSPEED: prdata = {16'h0000, hspd_r};
      REG_VSPEED: prdata = {16'h0000, vspd_r};
      REG_TURN:   prdata = {16'h0000, turn_r};
      REG_MODE:   prdata = {31'h00000000, rmode_r};
      default:    prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_vel_x       = out_vx_r;
  assign out_vel_y       = out_vy_r;
  assign out_vel_z       = out_vz_r;
  assign out_yaw_rate    = out_yaw_r;
  assign out_quat_z      = out_qz_r;
  assign out_quat_w      = out_qw_r;
  assign out_orient_mode = out_mode_r;

  `STV_ASSERT_IMP(a_cs_done_wait, cs_done, state_r == ST_ROT || state_r == ST_QUAT, "stray cordic done")
  `STV_ASSERT_IMP(a_done_seeded, state_r == ST_DONE, tgt_vld_r, "result with unseeded reference")
  `STV_ASSERT_IMP(a_att_no_rate, out_valid && out_orient_mode, out_yaw_rate == '0, "yaw rate in attitude mode")
  `STV_ASSERT_IMP(a_rate_no_quat, out_valid && !out_orient_mode, out_quat_z == '0 && out_quat_w == '0, "quaternion in rate mode")

endmodule
